// ===== hdl/gdf_pkg.sv =====
// shared types, constants and the log2 fraction table for gain_to_dac_frame
// no dependencies; imported by every module of the block

package gdf_pkg;

  localparam int GAIN_FRAC_BITS    = 11;
  localparam int LOG_TABLE_ENTRIES = 256;

  localparam int GAIN_W = 16;
  localparam int CODE_W = 12;
  localparam int IDX_W  = $clog2(LOG_TABLE_ENTRIES);
  localparam int WF_W   = 16 - IDX_W;
  localparam int EXP_W  = $clog2(17 - GAIN_FRAC_BITS);
  localparam int LOG2_W = 16 + EXP_W;
  localparam int ROM_W  = 17;
  localparam int CLAMP_W = GAIN_W + 2;

  // fine law: (4096/5 * g) rounded, as floor(((g << (13 - frac)) + 5) / 10)
  localparam int NUM_W      = 15;
  localparam int RECIP_W    = 16;
  localparam int FINE_RECIP = 52429;
  localparam int FINE_SHIFT = 19;
  localparam int PROD_W     = NUM_W + RECIP_W;

  // coarse law scale: log10(2) * 0.6 * 4096 / 2.5 in Q16
  localparam int SCALE_W      = 25;
  localparam int LOG_SCALE_Q16 = 19393710;
  localparam int SC_W         = LOG2_W + SCALE_W + 1;

  localparam logic [CLAMP_W-1:0] GAIN_ONE     = CLAMP_W'(1 << GAIN_FRAC_BITS);
  localparam logic [CLAMP_W-1:0] GAIN_FINE_HI = CLAMP_W'(2 << GAIN_FRAC_BITS);
  localparam logic [CLAMP_W-1:0] GAIN_CRS_HI  = CLAMP_W'(21 << GAIN_FRAC_BITS);

  localparam logic [7:0] CMD_REFERENCE = 8'h70;
  localparam logic [7:0] CMD_DAC_A     = 8'h31;
  localparam logic [7:0] CMD_DAC_B     = 8'h38;
  localparam logic [CODE_W-1:0] CODE_MAX = 12'hFFF;

  typedef enum logic [1:0] {
    KIND_REF    = 2'd0,
    KIND_FINE   = 2'd1,
    KIND_COARSE = 2'd2,
    KIND_RAW    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [NUM_W-1:0]   fine_num;
    logic [CODE_W-1:0]  raw;
    logic [EXP_W-1:0]   expo;
    logic [IDX_W-1:0]   idx;
    logic [WF_W-1:0]    wf;
  } front_t;

  typedef struct packed {
    kind_e              kind;
    logic [PROD_W-1:0]  fine_prod;
    logic [CODE_W-1:0]  raw;
    logic [EXP_W-1:0]   expo;
    logic [ROM_W-1:0]   t0;
    logic [ROM_W-1:0]   diff;
    logic [WF_W-1:0]    wf;
  } tab_t;

  typedef struct packed {
    kind_e              kind;
    logic [CODE_W-1:0]  lin_code;
    logic [LOG2_W-1:0]  log2;
  } lg_t;

  typedef struct packed {
    logic [CODE_W-1:0]  dac_code;
    logic [7:0]         data_low;
    logic [7:0]         data_high;
    logic [7:0]         cmd_byte;
  } frame_t;

  typedef logic [ROM_W-1:0] log_rom_t [LOG_TABLE_ENTRIES+1];

  // log2(1 + i/entries) in Q16, by repeated squaring, evaluated at elaboration
  function automatic log_rom_t build_log_rom();
    log_rom_t    rom;
    logic [63:0] y;
    logic [19:0] bits;
    for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
      y = (64'd1 << 30) + ((64'(i) << 30) / 64'(LOG_TABLE_ENTRIES));
      bits = '0;
      for (int k = 0; k < 20; k++) begin
        y = (y * y) >> 30;
        bits = {bits[18:0], 1'b0};
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          bits[0] = 1'b1;
        end
      end
      rom[i] = ROM_W'((21'(bits) + 21'd8) >> 4);
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

// ===== hdl/gdf_front.sv =====
// first stage: gain clamping, fine-law numerator and leading-one normalization
// depends on gdf_pkg

module gdf_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  gdf_pkg::kind_e         kind_i,
  input  logic [15:0]            gain_q_i,
  input  logic [15:0]            raw_code_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output gdf_pkg::front_t        out_o
);
  import gdf_pkg::*;

  logic                valid_q;
  front_t              data_q, data_d;
  logic [CLAMP_W-1:0]  gain_ext, gain_fine, gain_crs;
  logic [GAIN_W-1:0]   gc;
  logic [3:0]          msb;
  logic [GAIN_W-1:0]   norm;
  logic [15:0]         frac;

  assign gain_ext = CLAMP_W'(gain_q_i);

  always_comb begin
    if (gain_ext < GAIN_ONE) begin
      gain_fine = GAIN_ONE;
    end else if (gain_ext > GAIN_FINE_HI) begin
      gain_fine = GAIN_FINE_HI;
    end else begin
      gain_fine = gain_ext;
    end
    if (gain_ext < GAIN_ONE) begin
      gain_crs = GAIN_ONE;
    end else if (gain_ext > GAIN_CRS_HI) begin
      gain_crs = GAIN_CRS_HI;
    end else begin
      gain_crs = gain_ext;
    end
  end

  assign gc = gain_crs[GAIN_W-1:0];

  // leading one of the clamped coarse gain
  always_comb begin
    msb = '0;
    for (int b = 0; b < GAIN_W; b++) begin
      if (gc[b]) begin
        msb = 4'(b);
      end
    end
  end

  assign norm = gc << (4'd15 - msb);
  assign frac = {norm[14:0], 1'b0};

  always_comb begin
    data_d          = data_q;
    data_d.kind     = kind_i;
    data_d.fine_num = NUM_W'((gain_fine << (13 - GAIN_FRAC_BITS)) + CLAMP_W'(5));
    data_d.raw      = raw_code_i[CODE_W-1:0];
    data_d.expo     = EXP_W'(msb - 4'(GAIN_FRAC_BITS));
    data_d.idx      = frac[15 -: IDX_W];
    data_d.wf       = frac[WF_W-1:0];
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// ===== hdl/gdf_log.sv =====
// second and third stages: table reads, fine-law reciprocal multiply,
// interpolation and log2 assembly; depends on gdf_pkg

module gdf_log (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gdf_pkg::front_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gdf_pkg::lg_t      out_o
);
  import gdf_pkg::*;

  logic                  tab_valid_q, lg_valid_q;
  logic                  tab_ready, lg_ready;
  tab_t                  tab_q, tab_d;
  lg_t                   lg_q, lg_d;
  logic [IDX_W:0]        addr0, addr1;
  logic [ROM_W-1:0]      t0, t1;
  logic [ROM_W+WF_W-1:0] ip_full;
  logic [ROM_W-1:0]      interp;

  // table stage
  assign addr0 = {1'b0, in_i.idx};
  assign addr1 = addr0 + (IDX_W+1)'(1);
  assign t0    = LOG_ROM[addr0];
  assign t1    = LOG_ROM[addr1];

  always_comb begin
    tab_d           = tab_q;
    tab_d.kind      = in_i.kind;
    tab_d.fine_prod = PROD_W'(in_i.fine_num) * PROD_W'(FINE_RECIP);
    tab_d.raw       = in_i.raw;
    tab_d.expo      = in_i.expo;
    tab_d.t0        = t0;
    tab_d.diff      = t1 - t0;
    tab_d.wf        = in_i.wf;
  end

  assign tab_ready  = !tab_valid_q || lg_ready;
  assign in_ready_o = tab_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_valid_q <= 1'b0;
    end else if (tab_ready) begin
      tab_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && tab_ready) begin
      tab_q <= tab_d;
    end
  end

  // interpolation stage
  assign ip_full = (ROM_W+WF_W)'(tab_q.diff) * (ROM_W+WF_W)'(tab_q.wf);
  assign interp  = ip_full[ROM_W+WF_W-1:WF_W];

  always_comb begin
    lg_d      = lg_q;
    lg_d.kind = tab_q.kind;
    if (tab_q.kind == KIND_RAW) begin
      lg_d.lin_code = tab_q.raw;
    end else begin
      lg_d.lin_code = tab_q.fine_prod[FINE_SHIFT +: CODE_W];
    end
    lg_d.log2 = {tab_q.expo, 16'd0} + LOG2_W'(tab_q.t0) + LOG2_W'(interp);
  end

  assign lg_ready = !lg_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_valid_q <= 1'b0;
    end else if (lg_ready) begin
      lg_valid_q <= tab_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_valid_q && lg_ready) begin
      lg_q <= lg_d;
    end
  end

  assign out_valid_o = lg_valid_q;
  assign out_o       = lg_q;

endmodule

// ===== hdl/gdf_frame.sv =====
// last stage: coarse-law scaling and rounding, code select and frame build
// depends on gdf_pkg; its register is the block's output register

module gdf_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gdf_pkg::lg_t      in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gdf_pkg::frame_t   out_o
);
  import gdf_pkg::*;

  logic                    valid_q;
  frame_t                  frame_q, frame_d;
  logic [SC_W-1:0]         scaled;
  logic [SC_W-33:0]        crs_full;
  logic [CODE_W-1:0]       crs_code, code;

  assign scaled   = SC_W'(in_i.log2) * SC_W'(LOG_SCALE_Q16) + (SC_W'(1) << 31);
  assign crs_full = scaled[SC_W-1:32];
  assign crs_code = (crs_full > (SC_W-32)'(CODE_MAX)) ? CODE_MAX : crs_full[CODE_W-1:0];

  always_comb begin
    frame_d = frame_q;
    case (in_i.kind)
      KIND_FINE: begin
        frame_d.cmd_byte = CMD_DAC_A;
        code = in_i.lin_code;
      end
      KIND_COARSE: begin
        frame_d.cmd_byte = CMD_DAC_B;
        code = crs_code;
      end
      KIND_RAW: begin
        frame_d.cmd_byte = CMD_DAC_A;
        code = in_i.lin_code;
      end
      default: begin
        frame_d.cmd_byte = CMD_REFERENCE;
        code = '0;
      end
    endcase
    frame_d.data_high = code[11:4];
    frame_d.data_low  = {code[3:0], 4'd0};
    frame_d.dac_code  = code;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      frame_q <= frame_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = frame_q;

endmodule

// ===== hdl/gain_to_dac_frame.sv =====
// gain to dac command frame converter, four register stages
// an input beat passes the front, table, interpolation and frame registers in that order
// throughput: one beat per cycle while the output is taken; each stage holds its beat until the next takes it
// reset: asynchronous, clears the stage valid bits only; no state between beats
// depends on gdf_pkg, gdf_front, gdf_log, gdf_frame

module gain_to_dac_frame (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // gain_q[15:0], raw_code[31:16]
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // cmd_byte[7:0], data_high[15:8],
                                        // data_low[23:16], dac_code[35:24], zero[39:36]
);
  import gdf_pkg::*;

  logic    fr_valid, fr_ready;
  front_t  fr_data;
  logic    lg_valid, lg_ready;
  lg_t     lg_data;
  frame_t  frame;
  kind_e   kind_in;

  assign kind_in = kind_e'(s_axis_tuser_i);

  gdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .kind_i      (kind_in),
    .gain_q_i    (s_axis_tdata_i[15:0]),
    .raw_code_i  (s_axis_tdata_i[31:16]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_o       (fr_data)
  );

  gdf_log u_log (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_i        (fr_data),
    .out_valid_o (lg_valid),
    .out_ready_i (lg_ready),
    .out_o       (lg_data)
  );

  gdf_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lg_valid),
    .in_ready_o  (lg_ready),
    .in_i        (lg_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (frame)
  );

  assign m_axis_tdata_o = {4'd0, frame};

`ifndef SYNTHESIS
  // an empty output register means every stage can take a beat
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_frame_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ({frame.data_high, frame.data_low[7:4]} == frame.dac_code) &&
                        (frame.data_low[3:0] == 4'd0))
    else $error("frame data bytes disagree with dac code");

  a_ref_zero_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (frame.cmd_byte == CMD_REFERENCE) |-> frame.dac_code == '0)
    else $error("reference setup beat carries a nonzero code");

  a_known_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (frame.cmd_byte == CMD_REFERENCE) ||
                        (frame.cmd_byte == CMD_DAC_A) ||
                        (frame.cmd_byte == CMD_DAC_B))
    else $error("unknown command byte");
`endif

endmodule
